// ===== design/assert_macros.svh =====
// Assertion helpers for the force step unit.
// Clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_CLK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== design/glfs_pkg.sv =====
// Shared types, codes and helpers of the graph layout force step unit.
// Used by glfs_ctrl, glfs_dp and the top level.
package glfs_pkg;

	localparam int NODE_DEPTH = 1024;
	localparam int IDX_W      = $clog2(NODE_DEPTH);
	localparam int DEG_W      = 11;

	localparam logic [DEG_W-1:0] DEG_MAX   = 11'd1024;
	localparam logic [16:0]      ONE_Q16   = 17'd65536;
	localparam logic [31:0]      TENTH_Q16 = 32'd6554;

	// item modes
	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_COUNT  = 3'd1;
	localparam logic [2:0] MODE_CENTER = 3'd2;
	localparam logic [2:0] MODE_LINK   = 3'd3;
	localparam logic [2:0] MODE_INTEG  = 3'd4;

	// register indexes
	localparam logic [2:0] REG_ALPHA  = 3'd0;
	localparam logic [2:0] REG_CENTER = 3'd1;
	localparam logic [2:0] REG_LINK   = 3'd2;
	localparam logic [2:0] REG_DIST   = 3'd3;
	localparam logic [2:0] REG_DECAY  = 3'd4;

	// multiplier jobs
	localparam logic [3:0] M_ACS  = 4'd0;
	localparam logic [3:0] M_CFPX = 4'd1;
	localparam logic [3:0] M_CFPY = 4'd2;
	localparam logic [3:0] M_VDX  = 4'd3;
	localparam logic [3:0] M_VDY  = 4'd4;
	localparam logic [3:0] M_DXX  = 4'd5;
	localparam logic [3:0] M_DYY  = 4'd6;
	localparam logic [3:0] M_AK   = 4'd7;
	localparam logic [3:0] M_RAK  = 4'd8;
	localparam logic [3:0] M_DXL  = 4'd9;
	localparam logic [3:0] M_DYL  = 4'd10;
	localparam logic [3:0] M_FXB  = 4'd11;
	localparam logic [3:0] M_FYB  = 4'd12;
	localparam logic [3:0] M_FXNB = 4'd13;
	localparam logic [3:0] M_FYNB = 4'd14;

	// divider jobs
	localparam logic [1:0] D_BIAS  = 2'd0;
	localparam logic [1:0] D_RATIO = 2'd1;
	localparam logic [1:0] D_L     = 2'd2;

	// datapath ops done without a serial unit
	localparam logic [2:0] A_NONE  = 3'd0;
	localparam logic [2:0] A_LOAD  = 3'd1;
	localparam logic [2:0] A_INC_S = 3'd2;
	localparam logic [2:0] A_INC_T = 3'd3;
	localparam logic [2:0] A_SYNC  = 3'd4;
	localparam logic [2:0] A_DIFF  = 3'd5;
	localparam logic [2:0] A_INTEG = 3'd6;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [DEG_W-1:0]   deg;
	} node_t;

	typedef struct packed {
		logic       take;
		logic       rd_en;
		logic       rd_sel;   // 0 first node, 1 second node
		logic       ld_s;
		logic       ld_t;
		logic       wr_en;
		logic       wr_sel;
		logic       mul_go;
		logic [3:0] mul_sel;
		logic       div_go;
		logic [1:0] div_sel;
		logic       sqrt_go;
		logic [2:0] alu;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       mul_busy;
		logic       div_busy;
		logic       sqrt_busy;
		logic       unit_done;
	} sts_t;

	function automatic logic signed [95:0] ext32(input logic signed [31:0] v);
		return {{64{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > 96'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -96'sh8000_0000)
			return -32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [47:0] abs48(input logic [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

// ===== design/graph_layout_force_step_unit.sv =====
// Top level of the graph layout force step unit.
// Depends on glfs_pkg, glfs_ctrl, glfs_dp and assert_macros.svh.
//
// Usage:
//   s_axis carries one request per transfer: tuser = mode, tdata = first
//   index, second index, load x, load y. m_axis returns one result per
//   request: tuser = mode echoed, tdata = node index, position, velocity and
//   degree of the first node after the operation. cfg_we/cfg_index/cfg_wdata
//   write the five registers; write them only while no request is in flight.
//   Requests are handled one at a time; the next is taken once the current
//   result sits in the output register. Write, read and count link use no
//   serial unit; integrate and center use two or three 32-step shift-add
//   multiplies, link spring ten multiplies, three 69-step restoring divides
//   and a 32-step square root, all on one shared set of serial units.
//   The node memory is not cleared: write a node before any request reads it.
//   Reset returns the registers to their defaults and drops any request in
//   flight. A stalled receiver holds the result; one more request may be
//   worked on meanwhile and then waits for the output register.
`include "assert_macros.svh"

module graph_layout_force_step_unit import glfs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [87:0]  s_axis_tdata,   // first_index, second_index, load_x, load_y, pad
	input  logic [2:0]   s_axis_tuser,   // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata,   // node_index, pos_x, pos_y, vel_x, vel_y, degree, pad
	output logic [2:0]   m_axis_tuser,   // done_mode
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_wdata
);

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] out_index;
	node_t            out_node;

	glfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	glfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_mode   (s_axis_tuser),
		.in_first  (s_axis_tdata[9:0]),
		.in_second (s_axis_tdata[19:10]),
		.in_x      (s_axis_tdata[51:20]),
		.in_y      (s_axis_tdata[83:52]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_mode  (m_axis_tuser),
		.out_index (out_index),
		.out_node  (out_node)
	);

	assign m_axis_tdata = {3'b000, out_node.deg, out_node.vy, out_node.vx,
		out_node.py, out_node.px, out_index};

	`ASSERT_CLK(a_one_unit_go, $onehot0({cmd.mul_go, cmd.div_go, cmd.sqrt_go}))
	`ASSERT_IMPL(a_go_when_free, cmd.mul_go || cmd.div_go || cmd.sqrt_go, !(sts.mul_busy || sts.div_busy || sts.sqrt_busy))
	`ASSERT_IMPL(a_ready_units_idle, s_axis_tready, !(sts.mul_busy || sts.div_busy || sts.sqrt_busy))
	`ASSERT_IMPL(a_mem_rw_excl, cmd.wr_en, !cmd.rd_en)

endmodule

// ===== design/glfs_ctrl.sv =====
// Sequencer of the force step unit: steps each item through memory
// accesses and unit jobs. Depends on glfs_pkg; drives glfs_dp.
module glfs_ctrl import glfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [5:0] ST_IDLE   = 6'd0;
	localparam logic [5:0] ST_DISP   = 6'd1;
	localparam logic [5:0] ST_LD_S   = 6'd2;
	localparam logic [5:0] ST_LD_T   = 6'd3;
	localparam logic [5:0] ST_WR_S   = 6'd4;
	localparam logic [5:0] ST_FIN_RD = 6'd5;
	localparam logic [5:0] ST_FIN_LD = 6'd6;
	localparam logic [5:0] ST_WAIT   = 6'd7;
	localparam logic [5:0] ST_CNT_T  = 6'd8;
	localparam logic [5:0] ST_CNT_WT = 6'd9;
	localparam logic [5:0] ST_CNT_SY = 6'd10;
	localparam logic [5:0] ST_CNT_S  = 6'd11;
	localparam logic [5:0] ST_C_ACS  = 6'd12;
	localparam logic [5:0] ST_C_X    = 6'd13;
	localparam logic [5:0] ST_C_Y    = 6'd14;
	localparam logic [5:0] ST_I_VX   = 6'd15;
	localparam logic [5:0] ST_I_VY   = 6'd16;
	localparam logic [5:0] ST_I_POS  = 6'd17;
	localparam logic [5:0] ST_L_D    = 6'd18;
	localparam logic [5:0] ST_L_SQX  = 6'd19;
	localparam logic [5:0] ST_L_SQY  = 6'd20;
	localparam logic [5:0] ST_L_SQRT = 6'd21;
	localparam logic [5:0] ST_L_B    = 6'd22;
	localparam logic [5:0] ST_L_R    = 6'd23;
	localparam logic [5:0] ST_L_AK   = 6'd24;
	localparam logic [5:0] ST_L_RAK  = 6'd25;
	localparam logic [5:0] ST_L_L    = 6'd26;
	localparam logic [5:0] ST_L_FX   = 6'd27;
	localparam logic [5:0] ST_L_FY   = 6'd28;
	localparam logic [5:0] ST_L_TX   = 6'd29;
	localparam logic [5:0] ST_L_TY   = 6'd30;
	localparam logic [5:0] ST_L_WT   = 6'd31;
	localparam logic [5:0] ST_L_SYN  = 6'd32;
	localparam logic [5:0] ST_L_SX   = 6'd33;
	localparam logic [5:0] ST_L_SY   = 6'd34;

	logic [5:0] state_q, state_n;
	logic [5:0] ret_q, ret_n;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		ret_n   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.mode == MODE_WRITE) begin
					cmd.alu = A_LOAD;
					state_n = ST_WR_S;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = 1'b0;
					state_n    = ST_LD_S;
				end
			end
			ST_LD_S: begin
				cmd.ld_s   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 1'b1;
				state_n    = ST_LD_T;
			end
			ST_LD_T: begin
				cmd.ld_t = 1'b1;
				case (sts.mode)
					MODE_COUNT:  state_n = ST_CNT_T;
					MODE_CENTER: state_n = ST_C_ACS;
					MODE_LINK:   state_n = ST_L_D;
					MODE_INTEG:  state_n = ST_I_VX;
					default:     state_n = ST_FIN_RD;
				endcase
			end
			ST_WR_S: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = 1'b0;
				state_n    = ST_FIN_RD;
			end
			ST_FIN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 1'b0;
				state_n    = ST_FIN_LD;
			end
			ST_FIN_LD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (sts.unit_done)
					state_n = ret_q;
			end
			// count link: target first, then source so a self link adds two
			ST_CNT_T: begin
				cmd.alu = A_INC_T;
				state_n = ST_CNT_WT;
			end
			ST_CNT_WT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = 1'b1;
				state_n    = ST_CNT_SY;
			end
			ST_CNT_SY: begin
				cmd.alu = A_SYNC;
				state_n = ST_CNT_S;
			end
			ST_CNT_S: begin
				cmd.alu = A_INC_S;
				state_n = ST_WR_S;
			end
			ST_C_ACS: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_ACS;
				state_n = ST_WAIT; ret_n = ST_C_X;
			end
			ST_C_X: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_CFPX;
				state_n = ST_WAIT; ret_n = ST_C_Y;
			end
			ST_C_Y: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_CFPY;
				state_n = ST_WAIT; ret_n = ST_WR_S;
			end
			ST_I_VX: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_VDX;
				state_n = ST_WAIT; ret_n = ST_I_VY;
			end
			ST_I_VY: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_VDY;
				state_n = ST_WAIT; ret_n = ST_I_POS;
			end
			ST_I_POS: begin
				cmd.alu = A_INTEG;
				state_n = ST_WR_S;
			end
			ST_L_D: begin
				cmd.alu = A_DIFF;
				state_n = ST_L_SQX;
			end
			ST_L_SQX: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_DXX;
				state_n = ST_WAIT; ret_n = ST_L_SQY;
			end
			ST_L_SQY: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_DYY;
				state_n = ST_WAIT; ret_n = ST_L_SQRT;
			end
			ST_L_SQRT: begin
				cmd.sqrt_go = 1'b1;
				state_n = ST_WAIT; ret_n = ST_L_B;
			end
			ST_L_B: begin
				cmd.div_go = 1'b1; cmd.div_sel = D_BIAS;
				state_n = ST_WAIT; ret_n = ST_L_R;
			end
			ST_L_R: begin
				cmd.div_go = 1'b1; cmd.div_sel = D_RATIO;
				state_n = ST_WAIT; ret_n = ST_L_AK;
			end
			ST_L_AK: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_AK;
				state_n = ST_WAIT; ret_n = ST_L_RAK;
			end
			ST_L_RAK: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_RAK;
				state_n = ST_WAIT; ret_n = ST_L_L;
			end
			ST_L_L: begin
				cmd.div_go = 1'b1; cmd.div_sel = D_L;
				state_n = ST_WAIT; ret_n = ST_L_FX;
			end
			ST_L_FX: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_DXL;
				state_n = ST_WAIT; ret_n = ST_L_FY;
			end
			ST_L_FY: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_DYL;
				state_n = ST_WAIT; ret_n = ST_L_TX;
			end
			ST_L_TX: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_FXB;
				state_n = ST_WAIT; ret_n = ST_L_TY;
			end
			ST_L_TY: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_FYB;
				state_n = ST_WAIT; ret_n = ST_L_WT;
			end
			ST_L_WT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = 1'b1;
				state_n    = ST_L_SYN;
			end
			// self link: source update starts from the updated target
			ST_L_SYN: begin
				cmd.alu = A_SYNC;
				state_n = ST_L_SX;
			end
			ST_L_SX: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_FXNB;
				state_n = ST_WAIT; ret_n = ST_L_SY;
			end
			ST_L_SY: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = M_FYNB;
				state_n = ST_WAIT; ret_n = ST_WR_S;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/glfs_dp.sv =====
// Datapath of the force step unit: node memory, configuration registers,
// shift-add multiplier, restoring divider and bit-serial square root.
// Depends on glfs_pkg; commanded by glfs_ctrl.
module glfs_dp import glfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [2:0]        in_mode,
	input  logic [IDX_W-1:0]  in_first,
	input  logic [IDX_W-1:0]  in_second,
	input  logic [31:0]       in_x,
	input  logic [31:0]       in_y,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [30:0]       cfg_wdata,
	output logic [2:0]        out_mode,
	output logic [IDX_W-1:0]  out_index,
	output node_t             out_node
);

	// configuration
	logic [16:0] alpha_q, cs_q, ls_q, vd_q;
	logic [30:0] ld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 17'd65536;
			cs_q    <= 17'd6554;
			ls_q    <= 17'd65536;
			ld_q    <= 31'd1966080;
			vd_q    <= 17'd39322;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA:  alpha_q <= cfg_wdata[16:0];
				REG_CENTER: cs_q    <= cfg_wdata[16:0];
				REG_LINK:   ls_q    <= cfg_wdata[16:0];
				REG_DIST:   ld_q    <= cfg_wdata;
				REG_DECAY:  vd_q    <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// item and working registers
	logic [2:0]         mode_q;
	logic [IDX_W-1:0]   first_q, second_q;
	logic [31:0]        lx_q, ly_q;
	node_t              sn_q, tn_q, rdata_q;
	logic signed [31:0] dx_q, dy_q, l_q;
	logic [63:0]        sq_q;
	logic [31:0]        dist_q;
	logic [16:0]        b_q;
	logic signed [63:0] ratio_q;
	logic [18:0]        ak_q, cf_q;
	logic signed [47:0] fx_q, fy_q;

	node_t node_mem_q [NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			node_mem_q[cmd.wr_sel ? second_q : first_q] <= cmd.wr_sel ? tn_q : sn_q;
		if (cmd.rd_en)
			rdata_q <= node_mem_q[cmd.rd_sel ? second_q : first_q];
	end

	// effective degrees, bias complement
	logic [DEG_W-1:0] ws, wt, wmin;
	logic [16:0]      nb;
	logic             same_idx;

	assign ws       = (sn_q.deg == '0) ? DEG_W'(1) : sn_q.deg;
	assign wt       = (tn_q.deg == '0) ? DEG_W'(1) : tn_q.deg;
	assign wmin     = (ws < wt) ? ws : wt;
	assign nb       = ONE_Q16 - b_q;
	assign same_idx = (first_q == second_q);

	// link deltas
	logic signed [95:0] dxw, dyw;
	logic signed [31:0] dxs, dys;

	always_comb begin
		dxw = (ext32(tn_q.px) + ext32(tn_q.vx)) - (ext32(sn_q.px) + ext32(sn_q.vx));
		dyw = (ext32(tn_q.py) + ext32(tn_q.vy)) - (ext32(sn_q.py) + ext32(sn_q.vy));
		dxs = sat32(dxw);
		dys = sat32(dyw);
	end

	// multiplier: sign-magnitude, one multiplier bit a cycle
	logic [63:0] ma;
	logic [31:0] mb;
	logic        mneg;

	always_comb begin
		ma   = '0;
		mb   = '0;
		mneg = 1'b0;
		case (cmd.mul_sel)
			M_ACS:  begin ma = 64'(alpha_q); mb = 32'(cs_q); end
			M_CFPX: begin ma = 64'(cf_q); mb = abs32(sn_q.px); mneg = sn_q.px[31]; end
			M_CFPY: begin ma = 64'(cf_q); mb = abs32(sn_q.py); mneg = sn_q.py[31]; end
			M_VDX:  begin ma = 64'(abs32(sn_q.vx)); mb = 32'(vd_q); mneg = sn_q.vx[31]; end
			M_VDY:  begin ma = 64'(abs32(sn_q.vy)); mb = 32'(vd_q); mneg = sn_q.vy[31]; end
			M_DXX:  begin ma = 64'(abs32(dx_q)); mb = abs32(dx_q); end
			M_DYY:  begin ma = 64'(abs32(dy_q)); mb = abs32(dy_q); end
			M_AK:   begin ma = 64'(alpha_q); mb = 32'(ls_q); end
			M_RAK:  begin ma = abs64(ratio_q); mb = 32'(ak_q); mneg = ratio_q[63]; end
			M_DXL:  begin ma = 64'(abs32(dx_q)); mb = abs32(l_q); mneg = dx_q[31] ^ l_q[31]; end
			M_DYL:  begin ma = 64'(abs32(dy_q)); mb = abs32(l_q); mneg = dy_q[31] ^ l_q[31]; end
			M_FXB:  begin ma = 64'(abs48(fx_q)); mb = 32'(b_q); mneg = fx_q[47]; end
			M_FYB:  begin ma = 64'(abs48(fy_q)); mb = 32'(b_q); mneg = fy_q[47]; end
			M_FXNB: begin ma = 64'(abs48(fx_q)); mb = 32'(nb); mneg = fx_q[47]; end
			M_FYNB: begin ma = 64'(abs48(fy_q)); mb = 32'(nb); mneg = fy_q[47]; end
			default: ;
		endcase
	end

	logic        m_busy_q, m_fin_q, m_neg_q;
	logic [4:0]  m_cnt_q;
	logic [3:0]  m_sel_q;
	logic [63:0] m_a_q;
	logic [95:0] m_p_q;
	logic [64:0] m_sum;

	assign m_sum = {1'b0, m_p_q[95:32]} + (m_p_q[0] ? {1'b0, m_a_q} : 65'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_busy_q <= 1'b0;
			m_fin_q  <= 1'b0;
			m_cnt_q  <= '0;
		end else begin
			m_fin_q <= 1'b0;
			if (cmd.mul_go) begin
				m_busy_q <= 1'b1;
				m_cnt_q  <= '0;
			end else if (m_busy_q) begin
				m_cnt_q <= m_cnt_q + 5'd1;
				if (m_cnt_q == 5'd31) begin
					m_busy_q <= 1'b0;
					m_fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			m_a_q   <= ma;
			m_p_q   <= {64'd0, mb};
			m_neg_q <= mneg;
			m_sel_q <= cmd.mul_sel;
		end else if (m_busy_q) begin
			m_p_q <= {m_sum, m_p_q[31:1]};
		end
	end

	// product shifted down 16 bits, half away from zero
	logic [96:0]        m_rnd;
	logic [80:0]        m_mag;
	logic signed [95:0] mres;

	always_comb begin
		m_rnd = {1'b0, m_p_q} + 97'd32768;
		m_mag = m_rnd[96:16];
		mres  = m_neg_q ? -$signed({15'd0, m_mag}) : $signed({15'd0, m_mag});
	end

	// divider: rounded quotient, one bit a cycle
	logic [67:0]        d_nmag;
	logic [31:0]        d_den;
	logic               d_neg;
	logic signed [33:0] d_diff;
	logic [33:0]        d_dmag;

	always_comb begin
		d_diff = $signed({2'b00, dist_q}) - $signed({3'b000, ld_q});
		d_dmag = d_diff[33] ? 34'(-d_diff) : d_diff;
		d_nmag = '0;
		d_den  = 32'd1;
		d_neg  = 1'b0;
		case (cmd.div_sel)
			D_BIAS: begin
				d_nmag = 68'({ws, 16'd0});
				d_den  = 32'({1'b0, ws} + {1'b0, wt});
			end
			D_RATIO: begin
				d_nmag = 68'({d_dmag, 16'd0});
				d_den  = dist_q;
				d_neg  = d_diff[33];
			end
			D_L: begin
				d_nmag = m_p_q[67:0];
				d_den  = 32'({wmin, 16'd0});
				d_neg  = m_neg_q;
			end
			default: ;
		endcase
	end

	logic        dv_busy_q, dv_fin_q, dv_neg_q;
	logic [6:0]  dv_cnt_q;
	logic [1:0]  dv_sel_q;
	logic [68:0] dv_q_q;
	logic [31:0] dv_rem_q, dv_den_q;
	logic [32:0] dv_t;
	logic        dv_ge;

	assign dv_t  = {dv_rem_q, dv_q_q[68]};
	assign dv_ge = dv_t >= {1'b0, dv_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_fin_q  <= 1'b0;
			dv_cnt_q  <= '0;
		end else begin
			dv_fin_q <= 1'b0;
			if (cmd.div_go) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= '0;
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q + 7'd1;
				if (dv_cnt_q == 7'd68) begin
					dv_busy_q <= 1'b0;
					dv_fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			dv_q_q   <= 69'(d_nmag) + 69'(d_den >> 1);
			dv_rem_q <= '0;
			dv_den_q <= d_den;
			dv_neg_q <= d_neg;
			dv_sel_q <= cmd.div_sel;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_ge ? 32'(dv_t - {1'b0, dv_den_q}) : dv_t[31:0];
			dv_q_q   <= {dv_q_q[67:0], dv_ge};
		end
	end

	logic signed [95:0] qres;
	assign qres = dv_neg_q ? -$signed({27'd0, dv_q_q}) : $signed({27'd0, dv_q_q});

	// integer square root, one result bit a cycle
	logic        sr_busy_q, sr_fin_q;
	logic [4:0]  sr_cnt_q;
	logic [63:0] sr_v_q, sr_r_q, sr_bit_q;
	logic [64:0] sr_rb;

	assign sr_rb = {1'b0, sr_r_q} + {1'b0, sr_bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_busy_q <= 1'b0;
			sr_fin_q  <= 1'b0;
			sr_cnt_q  <= '0;
		end else begin
			sr_fin_q <= 1'b0;
			if (cmd.sqrt_go) begin
				sr_busy_q <= 1'b1;
				sr_cnt_q  <= '0;
			end else if (sr_busy_q) begin
				sr_cnt_q <= sr_cnt_q + 5'd1;
				if (sr_cnt_q == 5'd31) begin
					sr_busy_q <= 1'b0;
					sr_fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_go) begin
			sr_v_q   <= sq_q;
			sr_r_q   <= '0;
			sr_bit_q <= 64'h4000_0000_0000_0000;
		end else if (sr_busy_q) begin
			if ({1'b0, sr_v_q} >= sr_rb) begin
				sr_v_q <= sr_v_q - sr_rb[63:0];
				sr_r_q <= (sr_r_q >> 1) + sr_bit_q;
			end else begin
				sr_r_q <= sr_r_q >> 1;
			end
			sr_bit_q <= sr_bit_q >> 2;
		end
	end

	// register updates
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q   <= in_mode;
			first_q  <= in_first;
			second_q <= in_second;
			lx_q     <= in_x;
			ly_q     <= in_y;
		end
		if (cmd.ld_s)
			sn_q <= rdata_q;
		if (cmd.ld_t)
			tn_q <= rdata_q;

		case (cmd.alu)
			A_LOAD: begin
				sn_q.px  <= lx_q;
				sn_q.py  <= ly_q;
				sn_q.vx  <= '0;
				sn_q.vy  <= '0;
				sn_q.deg <= '0;
			end
			A_INC_S: if (sn_q.deg < DEG_MAX) sn_q.deg <= sn_q.deg + DEG_W'(1);
			A_INC_T: if (tn_q.deg < DEG_MAX) tn_q.deg <= tn_q.deg + DEG_W'(1);
			A_SYNC:  if (same_idx) sn_q <= tn_q;
			A_DIFF: begin
				dx_q <= (dxs == '0) ? TENTH_Q16 : dxs;
				dy_q <= (dys == '0) ? TENTH_Q16 : dys;
			end
			A_INTEG: begin
				sn_q.px <= sat32(ext32(sn_q.px) + ext32(sn_q.vx));
				sn_q.py <= sat32(ext32(sn_q.py) + ext32(sn_q.vy));
			end
			default: ;
		endcase

		if (m_fin_q) begin
			case (m_sel_q)
				M_ACS:  cf_q    <= m_mag[18:0];
				M_CFPX: sn_q.vx <= sat32(ext32(sn_q.vx) - mres);
				M_CFPY: sn_q.vy <= sat32(ext32(sn_q.vy) - mres);
				M_VDX:  sn_q.vx <= sat32(mres);
				M_VDY:  sn_q.vy <= sat32(mres);
				M_DXX:  sq_q    <= m_p_q[63:0];
				M_DYY:  sq_q    <= sq_q + m_p_q[63:0];
				M_AK:   ak_q    <= m_mag[18:0];
				M_DXL:  fx_q    <= mres[47:0];
				M_DYL:  fy_q    <= mres[47:0];
				M_FXB:  tn_q.vx <= sat32(ext32(tn_q.vx) - mres);
				M_FYB:  tn_q.vy <= sat32(ext32(tn_q.vy) - mres);
				M_FXNB: sn_q.vx <= sat32(ext32(sn_q.vx) + mres);
				M_FYNB: sn_q.vy <= sat32(ext32(sn_q.vy) + mres);
				default: ;  // ratio*ak stays in the product register
			endcase
		end

		if (dv_fin_q) begin
			case (dv_sel_q)
				D_BIAS:  b_q     <= dv_q_q[16:0];
				D_RATIO: ratio_q <= qres[63:0];
				D_L:     l_q     <= sat32(qres);
				default: ;
			endcase
		end

		if (sr_fin_q)
			dist_q <= sr_r_q[31:0];

		if (cmd.out_load) begin
			out_mode  <= mode_q;
			out_index <= first_q;
			out_node  <= rdata_q;
		end
	end

	assign sts.mode      = mode_q;
	assign sts.mul_busy  = m_busy_q;
	assign sts.div_busy  = dv_busy_q;
	assign sts.sqrt_busy = sr_busy_q;
	assign sts.unit_done = m_fin_q | dv_fin_q | sr_fin_q;

endmodule
